@@ design/mcp_pkg.sv @@
// Shared types, constants and helper functions of the motor command parser.
package mcp_pkg;

   // Framing buffer and speed scale
   localparam int BUFFER_BYTES = 32;
   localparam int IDX_W        = $clog2(BUFFER_BYTES);
   localparam int HEAD_DEPTH   = 6;
   localparam int FULL_SCALE   = 50;
   localparam int LEVEL_W      = $clog2(FULL_SCALE + 1);
   localparam int STEP_W       = 6;
   localparam int ARITH_W      = ((LEVEL_W > STEP_W) ? LEVEL_W : STEP_W) + 1;

   // Packet lengths checked at the closing brace, and the last buffer index
   localparam logic [IDX_W-1:0] MIN_LENGTH    = IDX_W'(4);
   localparam logic [IDX_W-1:0] MOTOR_LENGTH  = IDX_W'(6);
   localparam logic [IDX_W-1:0] ENABLE_LENGTH = IDX_W'(5);
   localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(BUFFER_BYTES - 1);

   // Character codes
   localparam logic [7:0] CH_OPEN      = 8'h7B;
   localparam logic [7:0] CH_CLOSE     = 8'h7D;
   localparam logic [7:0] CH_ACTION    = 8'h63;
   localparam logic [7:0] CMD_MOTOR    = 8'd77;
   localparam logic [7:0] CMD_ENABLE   = 8'd72;
   localparam logic [7:0] VAL_ON       = 8'd48;
   localparam logic [7:0] VAL_OFF      = 8'd49;
   localparam logic [7:0] SPEED_OFFSET = 8'd50;

   // Status codes
   localparam logic [2:0] ST_IDLE          = 3'd0;
   localparam logic [2:0] ST_FRAME_START   = 3'd1;
   localparam logic [2:0] ST_BYTE_STORED   = 3'd2;
   localparam logic [2:0] ST_APPLIED       = 3'd3;
   localparam logic [2:0] ST_TOO_SHORT     = 3'd4;
   localparam logic [2:0] ST_WRONG_ADDRESS = 3'd5;
   localparam logic [2:0] ST_BAD_SIZE      = 3'd6;
   localparam logic [2:0] ST_IGNORED       = 3'd7;

   // Bridge direction codes
   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_LOW        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_HIGH       = 2'd3;

   // Command queue between parser and motor unit
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Duty scaling: divide by FULL_SCALE through a reciprocal multiply
   localparam int PROD_W      = LEVEL_W + 1 + 9;
   localparam int ABS_W       = PROD_W - 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = (2**RECIP_SHIFT + FULL_SCALE - 1) / FULL_SCALE;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int QUOT_W      = ABS_W + RECIP_W;

   typedef enum logic [2:0] {
      OP_REPORT,
      OP_TICK,
      OP_MOTOR,
      OP_ENABLE,
      OP_DISABLE
   } op_kind_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic [1:0] left_direction;
      logic [1:0] right_direction;
      logic       pwm_active;
      logic       motors_enabled;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]        device_address;
      logic [STEP_W-1:0] ramp_step;
      logic [7:0]        pwm_low;
      logic [7:0]        pwm_high;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         dir;
      logic [LEVEL_W-1:0] target;
   } side_type;

   // Classified command from parser to motor unit
   typedef struct packed {
      op_kind_type kind;
      logic [2:0]  status;
      side_type    left;
      side_type    right;
   } op_type;

   // Motor state snapshot after one transaction
   typedef struct packed {
      logic [2:0]         status;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
      logic [1:0]         left_dir;
      logic [1:0]         right_dir;
      logic               held_low;
      logic               enable;
   } snap_type;

   // Speed byte to direction and clamped magnitude
   function automatic side_type set_side(input logic [7:0] b);
      side_type   s;
      logic [7:0] mag;
      if (b < SPEED_OFFSET) begin
         s.dir = DIR_REV;
         mag   = SPEED_OFFSET - b;
      end else if (b == SPEED_OFFSET) begin
         s.dir = DIR_OFF;
         mag   = 8'd0;
      end else begin
         s.dir = DIR_FWD;
         mag   = b - SPEED_OFFSET;
      end
      if (mag > 8'(FULL_SCALE)) begin
         s.target = LEVEL_W'(FULL_SCALE);
      end else begin
         s.target = mag[LEVEL_W-1:0];
      end
      return s;
   endfunction

   // One ramp step of a level toward its target
   function automatic logic [LEVEL_W-1:0] step_one(input logic [LEVEL_W-1:0] level,
                                                   input logic [LEVEL_W-1:0] target,
                                                   input logic [STEP_W-1:0]  step);
      logic [ARITH_W-1:0] lv;
      logic [ARITH_W-1:0] tg;
      logic [ARITH_W-1:0] st;
      logic [ARITH_W-1:0] res;
      lv = ARITH_W'(level);
      tg = ARITH_W'(target);
      st = ARITH_W'(step);
      if (tg > lv && (tg - lv) > st) begin
         res = lv + st;
      end else if (lv > tg && (lv - tg) > st) begin
         res = lv - st;
      end else begin
         res = tg;
      end
      return res[LEVEL_W-1:0];
   endfunction

endpackage

@@ design/mcp_chan_if.sv @@
// Valid/ready channel carrying one payload struct per transaction.
interface mcp_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/mcp_front.sv @@
// Packet framer and command classifier: turns bytes and ticks into queued commands.
module mcp_front import mcp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mcp_chan_if.sink   req_chan,
   input  logic [7:0] device_address,
   input  logic       queue_ready,
   output logic       push,
   output op_type     push_op
);

   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [IDX_W-1:0] text_length_ff, text_length_in;
   logic             zero_seen_ff, zero_seen_in;
   logic [7:0]       head_ff [HEAD_DEPTH];
   logic [7:0]       head_in [HEAD_DEPTH];
   logic [7:0]       rx;

   assign req_chan.ready = queue_ready;
   assign push           = req_chan.valid && queue_ready;
   assign rx             = req_chan.data.rx_byte;

   // Framing and classification of one transaction
   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_index_in  = byte_index_ff;
      text_length_in = text_length_ff;
      zero_seen_in   = zero_seen_ff;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_in[i] = head_ff[i];
      end
      push_op.kind   = OP_REPORT;
      push_op.status = ST_IDLE;
      push_op.left   = set_side(head_ff[4]);
      push_op.right  = set_side(head_ff[5]);

      if (push) begin
         if (req_chan.data.func) begin
            push_op.kind = OP_TICK;
         end else if (rx == CH_OPEN) begin
            in_frame_in    = 1'b1;
            byte_index_in  = '0;
            text_length_in = '0;
            zero_seen_in   = 1'b0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
               head_in[i] = 8'd0;
            end
            push_op.status = ST_FRAME_START;
         end else if (in_frame_ff) begin
            if (rx == CH_CLOSE) begin
               in_frame_in   = 1'b0;
               byte_index_in = '0;
               // Packet checks at the closing brace
               if (text_length_ff < MIN_LENGTH) begin
                  push_op.status = ST_TOO_SHORT;
               end else if (head_ff[0] != device_address) begin
                  push_op.status = ST_WRONG_ADDRESS;
               end else if (head_ff[2] != CH_ACTION) begin
                  push_op.status = ST_IGNORED;
               end else if (head_ff[3] == CMD_MOTOR) begin
                  if (text_length_ff != MOTOR_LENGTH) begin
                     push_op.status = ST_BAD_SIZE;
                  end else begin
                     push_op.kind = OP_MOTOR;
                  end
               end else if (head_ff[3] == CMD_ENABLE) begin
                  if (text_length_ff != ENABLE_LENGTH) begin
                     push_op.status = ST_BAD_SIZE;
                  end else if (head_ff[4] == VAL_ON) begin
                     push_op.kind = OP_ENABLE;
                  end else if (head_ff[4] == VAL_OFF) begin
                     push_op.kind = OP_DISABLE;
                  end else begin
                     push_op.status = ST_IGNORED;
                  end
               end else begin
                  push_op.status = ST_IGNORED;
               end
            end else begin
               // Store head bytes, track length up to the first zero byte
               for (int i = 0; i < HEAD_DEPTH; i++) begin
                  if (byte_index_ff == IDX_W'(i)) begin
                     head_in[i] = rx;
                  end
               end
               if (byte_index_ff < LAST_INDEX) begin
                  if (rx == 8'd0) begin
                     zero_seen_in = 1'b1;
                  end else if (!zero_seen_ff) begin
                     text_length_in = byte_index_ff + 1'b1;
                  end
                  byte_index_in = byte_index_ff + 1'b1;
               end
               push_op.status = ST_BYTE_STORED;
            end
         end
      end
   end

   // Frame control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_index_ff  <= '0;
         text_length_ff <= '0;
         zero_seen_ff   <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         byte_index_ff  <= byte_index_in;
         text_length_ff <= text_length_in;
         zero_seen_ff   <= zero_seen_in;
      end
   end

   // Head bytes, cleared at every frame start
   always_ff @(posedge clock) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_ff[i] <= head_in[i];
      end
   end

endmodule

@@ design/mcp_queue.sv @@
// Short command queue between the parser and the motor unit.
module mcp_queue import mcp_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   ready,
   input  logic   pop,
   output logic   valid,
   output op_type head_op
);

   op_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign ready   = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign head_op = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count missed a push");
`endif

endmodule

@@ design/mcp_back.sv @@
// Motor unit: executes queued commands on enable, targets, levels and directions.
module mcp_back import mcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  op_type            q_op,
   output logic              q_pop,
   input  logic [STEP_W-1:0] ramp_step,
   output logic              snap_valid,
   output snap_type          snap,
   input  logic              snap_ready
);

   logic               enable_ff, enable_in;
   logic               held_low_ff, held_low_in;
   logic [LEVEL_W-1:0] left_target_ff, left_target_in;
   logic [LEVEL_W-1:0] right_target_ff, right_target_in;
   logic [LEVEL_W-1:0] left_level_ff, left_level_in;
   logic [LEVEL_W-1:0] right_level_ff, right_level_in;
   logic [1:0]         left_dir_ff, left_dir_in;
   logic [1:0]         right_dir_ff, right_dir_in;
   logic               ramp_en;
   logic [2:0]         status;
   logic               snap_valid_ff, snap_valid_in;
   snap_type           snap_ff, snap_in;

   assign q_pop      = q_valid && (!snap_valid_ff || snap_ready);
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   // Command execution
   always_comb begin
      enable_in       = enable_ff;
      held_low_in     = held_low_ff;
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      left_dir_in     = left_dir_ff;
      right_dir_in    = right_dir_ff;
      ramp_en         = 1'b0;
      status          = ST_IDLE;
      if (q_pop) begin
         case (q_op.kind)
            OP_TICK: begin
               ramp_en = 1'b1;
               if (enable_ff) begin
                  held_low_in = 1'b0;
               end
            end
            OP_MOTOR: begin
               if (!enable_ff) begin
                  held_low_in = 1'b1;
                  status      = ST_IGNORED;
               end else begin
                  left_target_in  = q_op.left.target;
                  right_target_in = q_op.right.target;
                  left_dir_in     = q_op.left.dir;
                  right_dir_in    = q_op.right.dir;
                  ramp_en         = 1'b1;
                  held_low_in     = 1'b0;
                  status          = ST_APPLIED;
               end
            end
            OP_ENABLE: begin
               enable_in = 1'b1;
               status    = ST_APPLIED;
            end
            OP_DISABLE: begin
               enable_in = 1'b0;
               status    = ST_APPLIED;
            end
            default: begin
               status = q_op.status;
            end
         endcase
      end
      left_level_in  = ramp_en ? step_one(left_level_ff, left_target_in, ramp_step)
                               : left_level_ff;
      right_level_in = ramp_en ? step_one(right_level_ff, right_target_in, ramp_step)
                               : right_level_ff;

      // Snapshot of the state this transaction leaves behind
      snap_in.status      = status;
      snap_in.left_level  = left_level_in;
      snap_in.right_level = right_level_in;
      snap_in.left_dir    = left_dir_in;
      snap_in.right_dir   = right_dir_in;
      snap_in.held_low    = held_low_in;
      snap_in.enable      = enable_in;
      if (q_pop) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         held_low_ff     <= 1'b0;
         left_target_ff  <= '0;
         right_target_ff <= '0;
         left_level_ff   <= '0;
         right_level_ff  <= '0;
         left_dir_ff     <= DIR_OFF;
         right_dir_ff    <= DIR_OFF;
         snap_valid_ff   <= 1'b0;
      end else begin
         enable_ff       <= enable_in;
         held_low_ff     <= held_low_in;
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         left_level_ff   <= left_level_in;
         right_level_ff  <= right_level_in;
         left_dir_ff     <= left_dir_in;
         right_dir_ff    <= right_dir_in;
         snap_valid_ff   <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         snap_ff <= snap_in;
      end
   end

`ifndef ASSERT_OFF
   a_disabled_motor_holds: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_op.kind == OP_MOTOR && !enable_ff) |=> held_low_ff)
      else $error("motor command while disabled did not hold PWM low");
`endif

endmodule

@@ design/mcp_duty.sv @@
// Duty computation pipeline: level times span, scaled by the full-scale reciprocal.
module mcp_duty import mcp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       snap_valid,
   input  snap_type   snap,
   output logic       snap_ready,
   input  logic [7:0] pwm_low,
   input  logic [7:0] pwm_high,
   mcp_chan_if.source rsp_chan
);

   logic                     mul_valid_ff, mul_valid_in;
   snap_type                 mul_snap_ff;
   logic signed [PROD_W-1:0] left_prod_ff, left_prod_in;
   logic signed [PROD_W-1:0] right_prod_ff, right_prod_in;
   logic signed [8:0]        span;
   logic                     out_valid_ff, out_valid_in;
   rsp_payload_type          out_ff, out_in;
   logic                     out_ready;
   logic                     mul_ready;

   assign out_ready  = !out_valid_ff || rsp_chan.ready;
   assign mul_ready  = !mul_valid_ff || out_ready;
   assign snap_ready = mul_ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   // Level times signed duty span
   assign span          = $signed({1'b0, pwm_high}) - $signed({1'b0, pwm_low});
   assign left_prod_in  = $signed({1'b0, snap.left_level}) * span;
   assign right_prod_in = $signed({1'b0, snap.right_level}) * span;
   assign mul_valid_in  = mul_ready ? snap_valid : mul_valid_ff;

   // Truncating divide by full scale, then offset by the low duty
   function automatic logic [7:0] scale_duty(input logic signed [PROD_W-1:0] prod,
                                             input logic [7:0] low);
      logic [PROD_W-1:0] mag_full;
      logic [QUOT_W-1:0] quot;
      logic [7:0]        q;
      mag_full = prod[PROD_W-1] ? (PROD_W'(0) - prod) : prod;
      quot     = QUOT_W'(mag_full[ABS_W-1:0]) * QUOT_W'(RECIP);
      q        = quot[RECIP_SHIFT +: 8];
      return prod[PROD_W-1] ? (low - q) : (low + q);
   endfunction

   always_comb begin
      out_in.status          = mul_snap_ff.status;
      out_in.left_duty       = mul_snap_ff.held_low ? 8'd0
                                                    : scale_duty(left_prod_ff, pwm_low);
      out_in.right_duty      = mul_snap_ff.held_low ? 8'd0
                                                    : scale_duty(right_prod_ff, pwm_low);
      out_in.left_direction  = mul_snap_ff.left_dir;
      out_in.right_direction = mul_snap_ff.right_dir;
      out_in.pwm_active      = !mul_snap_ff.held_low;
      out_in.motors_enabled  = mul_snap_ff.enable;
      out_valid_in           = out_ready ? mul_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (mul_ready && snap_valid) begin
         mul_snap_ff   <= snap;
         left_prod_ff  <= left_prod_in;
         right_prod_ff <= right_prod_in;
      end
      if (out_ready && mul_valid_ff) begin
         out_ff <= out_in;
      end
   end

`ifndef ASSERT_OFF
   a_held_low_duty_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.pwm_active) |-> (out_ff.left_duty == 8'd0 &&
                                                out_ff.right_duty == 8'd0))
      else $error("duty not zero while PWM held low");
`endif

endmodule

@@ design/motor_command_parser_ramp_driver.sv @@
// Motor command parser and ramp driver: one req_ transaction (a received byte or a ramp
// tick) gives exactly one rsp_ transaction with status, duties, directions and flags. A new
// transaction is taken every cycle while the command queue has room; a result passes through
// the four-entry command queue, written at the accepting edge, then the motor unit's snapshot
// register, the duty multiply register and the reciprocal scale into the output register. The
// parser stalls only when the queue is full, which happens only while the result side holds
// back. Configuration is written through csr_we/csr_index/csr_wdata and must only change
// while no transaction is in flight.
module motor_command_parser_ramp_driver import mcp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mcp_chan_if.sink             req_chan,
   mcp_chan_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   op_type   push_op;
   logic     queue_ready;
   logic     q_valid;
   logic     q_pop;
   op_type   q_op;
   logic     snap_valid;
   snap_type snap;
   logic     snap_ready;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            CSR_RAMP_STEP:      cfg_in.ramp_step      = csr_wdata[STEP_W-1:0];
            CSR_PWM_LOW:        cfg_in.pwm_low        = csr_wdata;
            CSR_PWM_HIGH:       cfg_in.pwm_high       = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= 8'd56;
         cfg_ff.ramp_step      <= STEP_W'(1);
         cfg_ff.pwm_low        <= 8'd150;
         cfg_ff.pwm_high       <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .device_address (cfg_ff.device_address),
      .queue_ready    (queue_ready),
      .push           (push),
      .push_op        (push_op)
   );

   mcp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .ready   (queue_ready),
      .pop     (q_pop),
      .valid   (q_valid),
      .head_op (q_op)
   );

   mcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_op       (q_op),
      .q_pop      (q_pop),
      .ramp_step  (cfg_ff.ramp_step),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   mcp_duty u_duty (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .pwm_low    (cfg_ff.pwm_low),
      .pwm_high   (cfg_ff.pwm_high),
      .rsp_chan   (rsp_chan)
   );

endmodule
